// ----- rtl/stg_pkg.sv -----
// Shared types and constants for the sine tone generator.
// Used by stg_mult, stg_sine, stg_div and sine_tone_generator; no dependencies.
package stg_pkg;

    // Field widths fixed by the register map and the stream items.
    localparam int TONE_W   = 15;
    localparam int RATE_W   = 18;
    localparam int VOL_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int MUL_W    = 16;
    localparam int PROD_W   = 2 * MUL_W;

    localparam int PHASE_BITS_DEF = 32;

    // Register map: byte address 4*index.
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_TONE   = 2'd0;
    localparam logic [1:0] REG_RATE   = 2'd1;
    localparam logic [1:0] REG_VOLUME = 2'd2;

    localparam logic [TONE_W-1:0] TONE_RST   = 15'd260;
    localparam logic [RATE_W-1:0] RATE_RST   = 18'd48000;
    localparam logic [VOL_W-1:0]  VOLUME_RST = 15'd4000;

    // Sine polynomial coefficients (Q15 scaling).
    localparam logic [MUL_W-1:0] SIN_A   = 16'd51472;
    localparam logic [MUL_W-1:0] SIN_B   = 16'd21024;
    localparam logic [MUL_W-1:0] SIN_C   = 16'd2320;
    localparam logic [MUL_W-1:0] SIN_MAX = 16'd32767;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } top_state_t;

    typedef enum logic [2:0] {
        SIN_IDLE,
        SIN_SQ,
        SIN_C2,
        SIN_ZT,
        SIN_ZA,
        SIN_SV,
        SIN_FIN
    } sin_state_t;

endpackage

// ----- rtl/stg_mult.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on stg_pkg for operand widths.
module stg_mult (
    input  logic                          clk,
    input  logic [stg_pkg::MUL_W-1:0]     op_a,
    input  logic [stg_pkg::MUL_W-1:0]     op_b,
    output logic [stg_pkg::PROD_W-1:0]    prod
);

    logic [stg_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/stg_sine.sv -----
// Sine evaluation and volume scaling, sequenced over one shared multiplier.
// Depends on stg_pkg and stg_mult.
module stg_sine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [stg_pkg::ANGLE_W-1:0]         angle,
    input  logic [stg_pkg::VOL_W-1:0]           volume,
    output stg_pkg::unit_stat_t                 stat,
    output logic signed [stg_pkg::SAMPLE_W-1:0] sample
);

    localparam int MW = stg_pkg::MUL_W;

    stg_pkg::sin_state_t state_reg, state_next;

    logic [MW-1:0]              zq_reg, zq_next;
    logic [MW-1:0]              z2_reg, z2_next;
    logic                       neg_reg, neg_next;
    logic                       done_reg, done_next;
    logic signed [MW-1:0]       sample_reg, sample_next;
    logic [MW-1:0]              op_a, op_b;
    logic [stg_pkg::PROD_W-1:0] prod;
    logic [MW-1:0]              prod_q15;
    logic [13:0]                r;
    logic [14:0]                z;

    assign prod_q15 = prod[30:15];
    assign r        = angle[13:0];
    assign z        = angle[14] ? 15'(15'd16384 - {1'b0, r}) : {1'b0, r};

    stg_mult u_mult (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stg_pkg::SIN_IDLE: if (start) state_next = stg_pkg::SIN_SQ;
            stg_pkg::SIN_SQ:   state_next = stg_pkg::SIN_C2;
            stg_pkg::SIN_C2:   state_next = stg_pkg::SIN_ZT;
            stg_pkg::SIN_ZT:   state_next = stg_pkg::SIN_ZA;
            stg_pkg::SIN_ZA:   state_next = stg_pkg::SIN_SV;
            stg_pkg::SIN_SV:   state_next = stg_pkg::SIN_FIN;
            stg_pkg::SIN_FIN:  state_next = stg_pkg::SIN_IDLE;
            default:           state_next = stg_pkg::SIN_IDLE;
        endcase
    end

    // Operand selection and data path
    always_comb
    begin
        op_a        = zq_reg;
        op_b        = zq_reg;
        zq_next     = zq_reg;
        z2_next     = z2_reg;
        neg_next    = neg_reg;
        done_next   = done_reg;
        sample_next = sample_reg;
        unique case (state_reg)
            stg_pkg::SIN_IDLE:
            begin
                if (start)
                begin
                    zq_next   = {z, 1'b0};
                    neg_next  = angle[15];
                    done_next = 1'b0;
                end
            end
            stg_pkg::SIN_SQ:
            begin
                op_a = zq_reg;
                op_b = zq_reg;
            end
            stg_pkg::SIN_C2:
            begin
                z2_next = prod_q15;
                op_a    = stg_pkg::SIN_C;
                op_b    = prod_q15;
            end
            stg_pkg::SIN_ZT:
            begin
                op_a = z2_reg;
                op_b = stg_pkg::SIN_B - prod_q15;
            end
            stg_pkg::SIN_ZA:
            begin
                op_a = zq_reg;
                op_b = stg_pkg::SIN_A - prod_q15;
            end
            stg_pkg::SIN_SV:
            begin
                op_a = (prod_q15 > stg_pkg::SIN_MAX) ? stg_pkg::SIN_MAX : prod_q15;
                op_b = {1'b0, volume};
            end
            stg_pkg::SIN_FIN:
            begin
                sample_next = neg_reg ? -$signed(prod_q15) : $signed(prod_q15);
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = done_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stg_pkg::SIN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zq_reg     <= zq_next;
        z2_reg     <= z2_next;
        neg_reg    <= neg_next;
        sample_reg <= sample_next;
    end

    assign stat.busy = (state_reg != stg_pkg::SIN_IDLE);
    assign stat.done = done_reg;
    assign sample    = sample_reg;

endmodule

// ----- rtl/stg_div.sv -----
// Restoring divider for the phase increment: (tone << PHASE_BITS) / rate.
// One quotient bit per cycle; depends on stg_pkg.
module stg_div #(
    parameter int PHASE_BITS = stg_pkg::PHASE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [stg_pkg::TONE_W-1:0]     tone,
    input  logic [stg_pkg::RATE_W-1:0]     rate,
    output stg_pkg::unit_stat_t            stat,
    output logic [PHASE_BITS-1:0]          incr
);

    localparam int TW     = stg_pkg::TONE_W;
    localparam int RW     = stg_pkg::RATE_W;
    localparam int STEPS  = TW + PHASE_BITS;
    localparam int CNT_W  = $clog2(STEPS + 1);
    localparam int TIDX_W = $clog2(TW);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [PHASE_BITS-1:0] quot_reg, quot_next;
    logic [TIDX_W-1:0]     tone_idx;
    logic                  dvd_bit;
    logic [RW:0]           trial;
    logic                  ge;

    assign tone_idx = TIDX_W'(TW - 1) - cnt_reg[TIDX_W-1:0];
    assign dvd_bit  = (cnt_reg < CNT_W'(TW)) ? tone[tone_idx] : 1'b0;
    assign trial    = {rem_reg, dvd_bit};
    assign ge       = (trial >= {1'b0, rate});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start && !busy_reg)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? RW'(trial - {1'b0, rate}) : trial[RW-1:0];
            quot_next = {quot_reg[PHASE_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    // A zero rate gives no increment: hold the phase.
    assign incr      = (rate == '0) ? '0 : quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/sine_tone_generator.sv -----
// Top level of the sine tone generator: register port, stream handshake, phase.
// Depends on stg_pkg, stg_sine and stg_div.
//
// Direct digital synthesis sine oscillator. Each item taken on the slave stream
// requests one audio sample; the result item carries sin(phase) * volume, truncated
// toward zero, on both the left and right halves of m_tdata, with m_tlast copying
// the request's batch_end bit. After each sample the phase (a PHASE_BITS-wide
// fraction of one turn, reset to zero) advances by floor(tone_hz * 2^PHASE_BITS /
// sample_rate) and wraps; a zero sample rate holds the phase. The bit-serial
// increment divider retires one quotient bit per cycle over 15 + PHASE_BITS steps;
// the sine polynomial and volume scaling run alongside it on one shared 16x16
// multiplier in six steps. Once both are done and the output register can take
// the sample, it is loaded there and shows on m_tvalid. s_tready is low while an
// item is in work. The finished sample sits in an output register, so the next
// request is taken while a result still waits on m_tready. Registers tone_hz (0x0),
// sample_rate (0x4) and volume (0x8) sit on the APB port and should be written
// only while no item is in work.
module sine_tone_generator #(
    parameter int PHASE_BITS = stg_pkg::PHASE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Sample requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [0] batch_end, [7:1] zero
    // Samples
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // [15:0] left_sample, [31:16] right_sample
    output logic                        m_tlast   // last_sample
);

    localparam int SW = stg_pkg::SAMPLE_W;

    stg_pkg::top_state_t state_reg, state_next;

    logic [stg_pkg::TONE_W-1:0] tone_reg;
    logic [stg_pkg::RATE_W-1:0] rate_reg;
    logic [stg_pkg::VOL_W-1:0]  volume_reg;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic                       last_reg, last_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_last_reg, out_last_next;
    logic signed [SW-1:0]       out_sample_reg, out_sample_next;

    logic                       cfg_write;
    logic [1:0]                 reg_idx;
    logic                       accept;
    logic                       calc_finish;
    logic                       slot_free;
    stg_pkg::unit_stat_t        sin_stat, div_stat;
    logic signed [SW-1:0]       sine_sample;
    logic [PHASE_BITS-1:0]      incr;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reg   <= stg_pkg::TONE_RST;
            rate_reg   <= stg_pkg::RATE_RST;
            volume_reg <= stg_pkg::VOLUME_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                stg_pkg::REG_TONE:   tone_reg   <= pwdata[stg_pkg::TONE_W-1:0];
                stg_pkg::REG_RATE:   rate_reg   <= pwdata[stg_pkg::RATE_W-1:0];
                stg_pkg::REG_VOLUME: volume_reg <= pwdata[stg_pkg::VOL_W-1:0];
                default:             ; // unmapped address: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            stg_pkg::REG_TONE:   prdata = 32'(tone_reg);
            stg_pkg::REG_RATE:   prdata = 32'(rate_reg);
            stg_pkg::REG_VOLUME: prdata = 32'(volume_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Compute units: both start on the accepted item and run side by side
    // ------------------------------------------------------------------
    assign accept = s_tvalid && s_tready;

    stg_sine u_sine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .angle  (phase_reg[PHASE_BITS-1 -: stg_pkg::ANGLE_W]),
        .volume (volume_reg),
        .stat   (sin_stat),
        .sample (sine_sample)
    );

    stg_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .tone  (tone_reg),
        .rate  (rate_reg),
        .stat  (div_stat),
        .incr  (incr)
    );

    // Finish once both units are done and the output register can take the sample.
    assign slot_free   = !out_valid_reg || m_tready;
    assign calc_finish = (state_reg == stg_pkg::ST_CALC) && sin_stat.done && div_stat.done
                         && slot_free;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stg_pkg::ST_IDLE: if (accept)      state_next = stg_pkg::ST_CALC;
            stg_pkg::ST_CALC: if (calc_finish) state_next = stg_pkg::ST_IDLE;
            default:                           state_next = stg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready        = (state_reg == stg_pkg::ST_IDLE);
        last_next       = accept ? s_tdata[0] : last_reg;
        phase_next      = calc_finish ? phase_reg + incr : phase_reg;
        out_sample_next = calc_finish ? sine_sample : out_sample_reg;
        out_last_next   = calc_finish ? last_reg : out_last_reg;
        if (calc_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stg_pkg::ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold until the next accept or finish.
    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sample_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // The phase moves only when a sample is handed to the output register.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !calc_finish |=> phase_reg == $past(phase_reg))
        else $error("phase changed without a finished sample");

    // A new item never starts while either unit is still working.
    a_units_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !sin_stat.busy && !div_stat.busy)
        else $error("item accepted while a compute unit is busy");

    // A finished sample never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        calc_finish |-> !out_valid_reg || m_tready)
        else $error("pending sample overwritten");

    // Left and right channels always agree.
    a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:16] == m_tdata[15:0])
        else $error("left and right samples differ");
`endif

endmodule
